FILE: sv/mspi_pkg.sv
// mspi_pkg: shared types, constants, duty clamp and the control program rom
// of the motor speed pi core. depends on nothing.
`timescale 1ns / 1ps

package mspi_pkg;

    localparam int unsigned FULL_DUTY   = 6553600;
    localparam int unsigned SPEED_MAX   = 1048575;
    // floor(x / 100) as (x * RECIP_100) >> RECIP_SHIFT, exact for x below 14e6
    localparam logic [23:0] RECIP_100   = 24'd10737419;
    localparam int unsigned RECIP_SHIFT = 30;
    localparam int unsigned STEP_W      = 5;
    localparam int unsigned DIV_W       = 24;
    localparam int unsigned DSR_W       = 16;
    localparam int unsigned CFG_IDX_W   = 4;
    localparam int unsigned CFG_DATA_W  = 24;

    // register reset values
    localparam logic [19:0] RST_TARGET   = 20'd8000;
    localparam logic [23:0] RST_RPM      = 24'd4687500;
    localparam logic [15:0] RST_P_GAIN   = 16'd1232;
    localparam logic [15:0] RST_I_GAIN   = 16'd19661;
    localparam logic [19:0] RST_FF_QUAD  = 20'd337897;
    localparam logic [15:0] RST_FF_LIN   = 16'd5625;
    localparam logic [22:0] RST_FF_CONST = 23'd4897505;
    localparam logic [15:0] RST_PWM      = 16'd37500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET   = 4'd0,
        REG_RPM      = 4'd1,
        REG_P_GAIN   = 4'd2,
        REG_I_GAIN   = 4'd3,
        REG_FF_QUAD  = 4'd4,
        REG_FF_LIN   = 4'd5,
        REG_FF_CONST = 4'd6,
        REG_PWM      = 4'd7
    } t_reg_idx;

    typedef struct packed {
        logic        mode;
        logic [15:0] elapsed_ticks;
    } t_in_word;

    typedef struct packed {
        logic [15:0] compare_value;
        logic [22:0] duty;
        logic [19:0] speed;
        logic        updated;
    } t_out_word;

    // multiplier operand pairs
    typedef enum logic [2:0] {
        MS_NONE, MS_P_ERR, MS_I_ERR, MS_T_T, MS_Q_LO, MS_Q_HI, MS_L_T, MS_D_PWM
    } t_msel;

    // datapath actions
    typedef enum logic [3:0] {
        AO_NOP, AO_CAPTURE, AO_P_LOAD, AO_INTEG, AO_TT, AO_QLO, AO_QHI, AO_LIN,
        AO_ADD_INT, AO_ADD_CONST, AO_DUTY, AO_DIV_PWM, AO_CMP, AO_DIV_SPEED,
        AO_SPEED, AO_EMIT
    } t_aop;

    // sequencer jump conditions
    typedef enum logic [2:0] {
        JC_NEXT, JC_WAIT_IN, JC_SLOT, JC_ZERO, JC_WAIT_DIV, JC_EMIT, JC_GOTO
    } t_jc;

    typedef struct packed {
        t_msel             msel;
        t_aop              aop;
        t_jc               jc;
        logic [STEP_W-1:0] target;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        t_msel msel;
        t_aop  aop;
        logic  go;
        logic  take;
    } t_ctl;

    // datapath to sequencer
    typedef struct packed {
        logic slot;
        logic ticks_zero;
        logic div_busy;
        logic out_stall;
    } t_stat;

    localparam logic [STEP_W-1:0] STEP_EMIT = 5'd16;
    localparam logic [STEP_W-1:0] STEP_SLOT = 5'd17;

    function automatic logic [22:0] clamp_duty(input logic signed [47:0] v);
        logic [22:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > 48'sd6553600) begin
            r = 23'(FULL_DUTY);
        end else begin
            r = v[22:0];
        end
        return r;
    endfunction

    // control program
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{msel: MS_NONE, aop: AO_NOP, jc: JC_GOTO, target: '0};
        case (step)
            5'd0:  w = '{msel: MS_NONE,  aop: AO_CAPTURE,   jc: JC_WAIT_IN,  target: '0};
            5'd1:  w = '{msel: MS_NONE,  aop: AO_NOP,       jc: JC_SLOT,     target: STEP_SLOT};
            5'd2:  w = '{msel: MS_P_ERR, aop: AO_NOP,       jc: JC_NEXT,     target: '0};
            5'd3:  w = '{msel: MS_I_ERR, aop: AO_P_LOAD,    jc: JC_NEXT,     target: '0};
            5'd4:  w = '{msel: MS_T_T,   aop: AO_INTEG,     jc: JC_NEXT,     target: '0};
            5'd5:  w = '{msel: MS_NONE,  aop: AO_TT,        jc: JC_NEXT,     target: '0};
            5'd6:  w = '{msel: MS_Q_LO,  aop: AO_NOP,       jc: JC_NEXT,     target: '0};
            5'd7:  w = '{msel: MS_Q_HI,  aop: AO_QLO,       jc: JC_NEXT,     target: '0};
            5'd8:  w = '{msel: MS_L_T,   aop: AO_QHI,       jc: JC_NEXT,     target: '0};
            5'd9:  w = '{msel: MS_NONE,  aop: AO_LIN,       jc: JC_NEXT,     target: '0};
            5'd10: w = '{msel: MS_NONE,  aop: AO_ADD_INT,   jc: JC_NEXT,     target: '0};
            5'd11: w = '{msel: MS_NONE,  aop: AO_ADD_CONST, jc: JC_NEXT,     target: '0};
            5'd12: w = '{msel: MS_NONE,  aop: AO_DUTY,      jc: JC_NEXT,     target: '0};
            5'd13: w = '{msel: MS_D_PWM, aop: AO_NOP,       jc: JC_NEXT,     target: '0};
            5'd14: w = '{msel: MS_NONE,  aop: AO_DIV_PWM,   jc: JC_NEXT,     target: '0};
            5'd15: w = '{msel: MS_NONE,  aop: AO_CMP,       jc: JC_NEXT,     target: '0};
            5'd16: w = '{msel: MS_NONE,  aop: AO_EMIT,      jc: JC_EMIT,     target: '0};
            5'd17: w = '{msel: MS_NONE,  aop: AO_DIV_SPEED, jc: JC_ZERO,     target: STEP_EMIT};
            5'd18: w = '{msel: MS_NONE,  aop: AO_SPEED,     jc: JC_WAIT_DIV, target: '0};
            5'd19: w = '{msel: MS_NONE,  aop: AO_NOP,       jc: JC_GOTO,     target: STEP_EMIT};
            default: w = '{msel: MS_NONE, aop: AO_NOP, jc: JC_GOTO, target: '0};
        endcase
        return w;
    endfunction

endpackage

FILE: sv/mspi_div.sv
// mspi_div: restoring divider, one quotient bit per cycle.
// depends on mspi_pkg for widths.
`timescale 1ns / 1ps

module mspi_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [mspi_pkg::DIV_W-1:0]      i_dividend,
    input  logic [mspi_pkg::DSR_W-1:0]      i_divisor,
    output logic                            o_busy,
    output logic [mspi_pkg::DIV_W-1:0]      o_quotient
);

    localparam int unsigned CNT_W = $clog2(mspi_pkg::DIV_W + 1);

    logic                           r_busy, n_busy;
    logic [CNT_W-1:0]               r_cnt, n_cnt;
    logic [mspi_pkg::DSR_W-1:0]     r_rem, n_rem;
    logic [mspi_pkg::DIV_W-1:0]     r_quo, n_quo;
    logic [mspi_pkg::DSR_W-1:0]     r_dsr, n_dsr;
    logic [mspi_pkg::DSR_W:0]       rem_sh;
    logic [mspi_pkg::DSR_W:0]       diff;

    assign rem_sh = {r_rem, r_quo[mspi_pkg::DIV_W-1]};
    assign diff   = rem_sh - {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(mspi_pkg::DIV_W);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_dsr}) begin
                n_rem = diff[mspi_pkg::DSR_W-1:0];
                n_quo = {r_quo[mspi_pkg::DIV_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[mspi_pkg::DSR_W-1:0];
                n_quo = {r_quo[mspi_pkg::DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

FILE: sv/mspi_useq.sv
// mspi_useq: step counter and program rom lookup with conditional jumps.
// depends on mspi_pkg for the rom and control types.
`timescale 1ns / 1ps

module mspi_useq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  mspi_pkg::t_stat     i_stat,
    output mspi_pkg::t_ctl      o_ctl
);

    logic [mspi_pkg::STEP_W-1:0] r_step, n_step;
    mspi_pkg::t_uword            uw;
    logic                        go;

    assign uw = mspi_pkg::ucode(r_step);

    always_comb begin
        go     = 1'b1;
        n_step = r_step + 1'b1;
        unique case (uw.jc)
            mspi_pkg::JC_WAIT_IN:  go = i_in_valid;
            mspi_pkg::JC_WAIT_DIV: go = !i_stat.div_busy;
            mspi_pkg::JC_EMIT: begin
                go     = !i_stat.out_stall;
                n_step = uw.target;
            end
            mspi_pkg::JC_GOTO:     n_step = uw.target;
            mspi_pkg::JC_SLOT: begin
                if (i_stat.slot) begin
                    n_step = uw.target;
                end
            end
            mspi_pkg::JC_ZERO: begin
                if (i_stat.ticks_zero) begin
                    n_step = uw.target;
                end
            end
            default: ;
        endcase
        if (!go) begin
            n_step = r_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctl.msel = uw.msel;
    assign o_ctl.aop  = uw.aop;
    assign o_ctl.go   = go;
    assign o_ctl.take = (uw.jc == mspi_pkg::JC_WAIT_IN);

endmodule

FILE: sv/mspi_dpath.sv
// mspi_dpath: config registers, loop state, shared multiplier, accumulator,
// divider and output register. depends on mspi_pkg and mspi_div.
`timescale 1ns / 1ps

module mspi_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mspi_pkg::t_ctl                      i_ctl,
    input  mspi_pkg::t_in_word                  i_in_word,
    input  logic                                i_cfg_valid,
    input  logic [mspi_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mspi_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output mspi_pkg::t_out_word                 o_out_word,
    output mspi_pkg::t_stat                     o_stat
);

    // config registers
    logic [19:0] r_target;
    logic [23:0] r_rpm;
    logic [15:0] r_p_gain;
    logic [15:0] r_i_gain;
    logic [19:0] r_ff_quad;
    logic [15:0] r_ff_lin;
    logic [22:0] r_ff_const;
    logic [15:0] r_pwm;

    // loop state
    logic [19:0] r_speed;
    logic [22:0] r_integ;
    logic [22:0] r_duty;
    logic [15:0] r_cmp;

    // item and scratch
    logic                r_mode;
    logic [15:0]         r_ticks;
    logic signed [45:0]  r_prod, n_prod;
    logic signed [47:0]  r_acc;
    logic [39:0]         r_tt;
    logic [19:0]         r_aux;
    logic [15:0]         r_scaled;
    logic                r_out_valid;
    mspi_pkg::t_out_word r_out;

    logic signed [20:0]  err;
    logic [23:0]         ma;
    logic signed [20:0]  mb;
    logic signed [47:0]  p_ext;
    logic signed [47:0]  p_s4;
    logic signed [47:0]  q_s4;
    logic signed [47:0]  integ_sum;
    logic [47:0]         scale_prod;
    logic                div_start;
    logic                div_busy;
    logic [mspi_pkg::DIV_W-1:0] quot;

    assign err = $signed({1'b0, r_target}) - $signed({1'b0, r_speed});

    always_comb begin
        ma = '0;
        mb = '0;
        unique case (i_ctl.msel)
            mspi_pkg::MS_P_ERR: begin ma = {8'd0, r_p_gain};  mb = err; end
            mspi_pkg::MS_I_ERR: begin ma = {8'd0, r_i_gain};  mb = err; end
            mspi_pkg::MS_T_T:   begin ma = {4'd0, r_target};  mb = {1'b0, r_target}; end
            mspi_pkg::MS_Q_LO:  begin ma = {4'd0, r_ff_quad}; mb = {1'b0, r_tt[19:0]}; end
            mspi_pkg::MS_Q_HI:  begin ma = {4'd0, r_ff_quad}; mb = {1'b0, r_tt[39:20]}; end
            mspi_pkg::MS_L_T:   begin ma = {8'd0, r_ff_lin};  mb = {1'b0, r_target}; end
            mspi_pkg::MS_D_PWM: begin ma = {1'b0, r_duty};    mb = {5'd0, r_pwm}; end
            default: ;
        endcase
    end

    assign n_prod    = $signed({1'b0, ma}) * mb;
    assign p_ext     = {{2{r_prod[45]}}, r_prod};
    assign p_s4      = p_ext >>> 4;
    // high partial plus carried low bits, then the final shift by 4
    assign q_s4      = (p_ext + $signed({28'd0, r_aux})) >>> 4;
    assign integ_sum = $signed({25'd0, r_integ}) + p_s4;

    // duty * period / 2^16, then divide by 100 through the reciprocal
    assign scale_prod = r_prod[39:16] * mspi_pkg::RECIP_100;

    assign div_start = i_ctl.go && (i_ctl.aop == mspi_pkg::AO_DIV_SPEED);

    mspi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_rpm),
        .i_divisor  (r_ticks),
        .o_busy     (div_busy),
        .o_quotient (quot)
    );

    // config writes, index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= mspi_pkg::RST_TARGET;
            r_rpm      <= mspi_pkg::RST_RPM;
            r_p_gain   <= mspi_pkg::RST_P_GAIN;
            r_i_gain   <= mspi_pkg::RST_I_GAIN;
            r_ff_quad  <= mspi_pkg::RST_FF_QUAD;
            r_ff_lin   <= mspi_pkg::RST_FF_LIN;
            r_ff_const <= mspi_pkg::RST_FF_CONST;
            r_pwm      <= mspi_pkg::RST_PWM;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mspi_pkg::REG_TARGET:   r_target   <= i_cfg_data[19:0];
                mspi_pkg::REG_RPM:      r_rpm      <= i_cfg_data[23:0];
                mspi_pkg::REG_P_GAIN:   r_p_gain   <= i_cfg_data[15:0];
                mspi_pkg::REG_I_GAIN:   r_i_gain   <= i_cfg_data[15:0];
                mspi_pkg::REG_FF_QUAD:  r_ff_quad  <= i_cfg_data[19:0];
                mspi_pkg::REG_FF_LIN:   r_ff_lin   <= i_cfg_data[15:0];
                mspi_pkg::REG_FF_CONST: r_ff_const <= i_cfg_data[22:0];
                mspi_pkg::REG_PWM:      r_pwm      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // loop state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed     <= '0;
            r_integ     <= '0;
            r_duty      <= '0;
            r_cmp       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.go && i_ctl.aop == mspi_pkg::AO_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_ctl.go) begin
                case (i_ctl.aop)
                    mspi_pkg::AO_INTEG: r_integ <= mspi_pkg::clamp_duty(integ_sum);
                    mspi_pkg::AO_DUTY:  r_duty  <= mspi_pkg::clamp_duty(r_acc);
                    mspi_pkg::AO_CMP:   r_cmp   <= r_pwm - r_scaled;
                    mspi_pkg::AO_SPEED: begin
                        if (quot > mspi_pkg::DIV_W'(mspi_pkg::SPEED_MAX)) begin
                            r_speed <= 20'(mspi_pkg::SPEED_MAX);
                        end else begin
                            r_speed <= quot[19:0];
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // scratch registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.go && i_ctl.msel != mspi_pkg::MS_NONE) begin
            r_prod <= n_prod;
        end
        if (i_ctl.go) begin
            case (i_ctl.aop)
                mspi_pkg::AO_CAPTURE: begin
                    r_mode  <= i_in_word.mode;
                    r_ticks <= i_in_word.elapsed_ticks;
                end
                mspi_pkg::AO_P_LOAD:    r_acc <= p_s4;
                mspi_pkg::AO_TT:        r_tt  <= r_prod[39:0];
                mspi_pkg::AO_QLO:       r_aux <= r_prod[39:20];
                mspi_pkg::AO_QHI:       r_acc <= r_acc + q_s4;
                mspi_pkg::AO_LIN:       r_acc <= r_acc - p_s4;
                mspi_pkg::AO_ADD_INT:   r_acc <= r_acc + $signed({25'd0, r_integ});
                mspi_pkg::AO_ADD_CONST: r_acc <= r_acc + $signed({25'd0, r_ff_const});
                mspi_pkg::AO_DIV_PWM:
                    r_scaled <= scale_prod[mspi_pkg::RECIP_SHIFT +: 16];
                mspi_pkg::AO_EMIT: begin
                    r_out.compare_value <= r_cmp;
                    r_out.duty          <= r_duty;
                    r_out.speed         <= r_speed;
                    r_out.updated       <= r_mode;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_word      = r_out;
    assign o_stat.slot       = !r_mode;
    assign o_stat.ticks_zero = (r_ticks == '0);
    assign o_stat.div_busy   = div_busy;
    assign o_stat.out_stall  = r_out_valid && !i_out_ready;

endmodule

FILE: sv/motor_speed_pi_feedforward_core.sv
// motor_speed_pi_feedforward_core: top level of the motor speed pi regulator
// with feedforward. depends on mspi_pkg, mspi_useq and mspi_dpath.
`timescale 1ns / 1ps

//  channel   dir  handshake                payload
//  in        in   i_in_valid / o_in_ready  i_in_word  (mode, elapsed_ticks)
//  out       out  o_out_valid / i_out_ready o_out_word (compare_value, duty, speed, updated)
//  cfg       in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  one word in gives one word out. a control tick walks the program steps in order
//  from the wait step through emit; the divide by 100 of the compare scaling
//  is a reciprocal multiply in one step. a slot pulse waits on the restoring divider
//  for the speed quotient, and skips that wait with a zero tick count.
//  reset is synchronous, active low; it loads the register defaults and clears
//  speed, integral, duty and compare. a stalled output holds the program at its
//  emit step, while the output register still frees one word of slack.

module motor_speed_pi_feedforward_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  mspi_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output mspi_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mspi_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mspi_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    mspi_pkg::t_ctl  ctl;
    mspi_pkg::t_stat stat;

    // program sequencer: step counter over the control rom
    mspi_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    // datapath: multiplier, accumulator, divider, state and config
    mspi_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .o_stat      (stat)
    );

    // input taken only at the wait step of the program
    assign o_in_ready  = ctl.take;
    // registers always writable
    assign o_cfg_ready = 1'b1;

    // a taken word moves the program off the wait step
    a_take_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("sequencer stayed at wait step after taking a word");

    // duty never leaves 0..100%
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.duty <= 23'(mspi_pkg::FULL_DUTY))
        else $error("duty out of range");

    // a new result is only loaded from the emit step, never while waiting for input
    a_emit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result emitted outside the emit step");

endmodule
